// ===== hw/rtl/dibc_pkg.sv =====
package dibc_pkg;

  localparam int TIME_BITS  = 32;
  localparam int SECS_W     = 16;
  localparam int THRESH_W   = 26;
  localparam int LEVEL_W    = 7;
  localparam int MODE_W     = 3;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 7'd100;
  localparam logic [LEVEL_W-1:0] MIN_PERCENT = 7'd1;
  localparam logic [LEVEL_W-1:0] MAX_PERCENT = 7'd100;
  localparam logic [LEVEL_W-1:0] OFF_LEVEL   = 7'd0;
  localparam logic [THRESH_W-1:0] MS_PER_SEC = 26'd1000;

  localparam logic [MODE_W-1:0] MODE_ACTIVE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIM    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLOCK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIM2   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd4;

  localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TOUCH    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_HOLD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ALERT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_SECS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SECS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_DIM_SECS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_SECS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_PERCENT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_DIM_PCT   = 3'd5;

  typedef struct packed {
    logic [SECS_W-1:0]  dim_seconds;
    logic [SECS_W-1:0]  clock_seconds;
    logic [SECS_W-1:0]  deep_dim_seconds;
    logic [SECS_W-1:0]  off_seconds;
    logic [LEVEL_W-1:0] dim_percent;
    logic [LEVEL_W-1:0] deep_dim_percent;
  } dibc_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               backlight_write;
    logic [LEVEL_W-1:0] backlight_level;
    logic               clock_changed;
    logic               clock_visible;
    logic               clock_refresh;
    logic               wake_swallowed;
    logic               tile_allowed;
    logic               hold_active;
  } dibc_res_t;

endpackage

// ===== hw/rtl/display_idle_backlight_controller_unit.sv =====
// Display idle manager. Events (tick, touch, release, set hold, alert wake) enter
// one word per cycle while in_stall is low. A word is held in the input register
// and then in the result register, which drives the out_ ports. The state update
// for a word happens as it moves from the input register to the result register,
// so a result held by out_stall still leaves room for one more word before in_stall
// rises. Threshold registers are in seconds, zero disables a level; percent writes
// clamp to 1..100. Write configuration only when idle.
module display_idle_backlight_controller_unit import dibc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [TIME_BITS-1:0]  in_now_ms,
  input  logic                  in_hold_request,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MODE_W-1:0]     out_mode,
  output logic                  out_backlight_write,
  output logic [LEVEL_W-1:0]    out_backlight_level,
  output logic                  out_clock_changed,
  output logic                  out_clock_visible,
  output logic                  out_clock_refresh,
  output logic                  out_wake_swallowed,
  output logic                  out_tile_allowed,
  output logic                  out_hold_active
);

  dibc_cfg_t cfg;
  dibc_res_t res;

  dibc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dibc_step u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_now_ms       (in_now_ms),
    .in_hold_request (in_hold_request),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .res             (res)
  );

  assign out_mode            = res.mode;
  assign out_backlight_write = res.backlight_write;
  assign out_backlight_level = res.backlight_level;
  assign out_clock_changed   = res.clock_changed;
  assign out_clock_visible   = res.clock_visible;
  assign out_clock_refresh   = res.clock_refresh;
  assign out_wake_swallowed  = res.wake_swallowed;
  assign out_tile_allowed    = res.tile_allowed;
  assign out_hold_active     = res.hold_active;

endmodule

// ===== hw/rtl/dibc_cfg.sv =====
module dibc_cfg import dibc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dibc_cfg_t             cfg
);

  dibc_cfg_t cfg_r;
  dibc_cfg_t cfg_nxt;

  function automatic logic [LEVEL_W-1:0] clamp_pct(input logic [LEVEL_W-1:0] v);
    logic [LEVEL_W-1:0] r;
    if (v < MIN_PERCENT) begin
      r = MIN_PERCENT;
    end else if (v > MAX_PERCENT) begin
      r = MAX_PERCENT;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DIM_SECS:      cfg_nxt.dim_seconds      = cfg_data;
        REG_CLOCK_SECS:    cfg_nxt.clock_seconds    = cfg_data;
        REG_DEEP_DIM_SECS: cfg_nxt.deep_dim_seconds = cfg_data;
        REG_OFF_SECS:      cfg_nxt.off_seconds      = cfg_data;
        REG_DIM_PERCENT:   cfg_nxt.dim_percent      = clamp_pct(cfg_data[LEVEL_W-1:0]);
        REG_DEEP_DIM_PCT:  cfg_nxt.deep_dim_percent = clamp_pct(cfg_data[LEVEL_W-1:0]);
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_seconds      <= 16'd30;
      cfg_r.clock_seconds    <= 16'd60;
      cfg_r.deep_dim_seconds <= 16'd300;
      cfg_r.off_seconds      <= 16'd600;
      cfg_r.dim_percent      <= 7'd30;
      cfg_r.deep_dim_percent <= 7'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hw/rtl/dibc_step.sv =====
module dibc_step import dibc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dibc_cfg_t            cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [TIME_BITS-1:0] in_now_ms,
  input  logic                 in_hold_request,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dibc_res_t            res
);

  // input stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic [FUNC_W-1:0]    s1_func_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 s1_hold_req_r;

  // block state
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic                 pend_r, pend_nxt;
  logic                 hold_r, hold_nxt;
  logic                 supp_r, supp_nxt;
  logic                 clk_vis_r, clk_vis_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;

  // result stage
  logic                 out_valid_r, out_valid_nxt;
  dibc_res_t            res_r, res_nxt;

  logic                 accept;
  logic                 advance;
  logic [TIME_BITS-1:0] idle;
  logic [MODE_W-1:0]    target;
  logic                 wrote;
  logic                 set_clk;
  logic                 refresh;
  logic                 swallowed;

  function automatic logic reached(input logic [TIME_BITS-1:0] idle_ms,
                                   input logic [SECS_W-1:0] secs);
    logic [THRESH_W-1:0] thresh;
    thresh = THRESH_W'(secs) * MS_PER_SEC;
    return (secs != '0) && (idle_ms >= TIME_BITS'(thresh));
  endfunction

  function automatic logic [LEVEL_W-1:0] mode_level(input logic [MODE_W-1:0] m,
                                                     input dibc_cfg_t c);
    logic [LEVEL_W-1:0] l;
    case (m)
      MODE_ACTIVE: l = FULL_LEVEL;
      MODE_DIM:    l = c.dim_percent;
      MODE_CLOCK:  l = c.dim_percent;
      MODE_DIM2:   l = c.deep_dim_percent;
      default:     l = OFF_LEVEL;
    endcase
    return l;
  endfunction

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  assign idle = s1_now_r - last_r;

  always_comb begin
    if (reached(idle, cfg.off_seconds)) begin
      target = MODE_OFF;
    end else if (reached(idle, cfg.deep_dim_seconds)) begin
      target = MODE_DIM2;
    end else if (reached(idle, cfg.clock_seconds)) begin
      target = MODE_CLOCK;
    end else if (reached(idle, cfg.dim_seconds)) begin
      target = MODE_DIM;
    end else begin
      target = MODE_ACTIVE;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    last_nxt    = last_r;
    pend_nxt    = pend_r;
    hold_nxt    = hold_r;
    supp_nxt    = supp_r;
    clk_vis_nxt = clk_vis_r;
    level_nxt   = level_r;
    wrote       = 1'b0;
    set_clk     = 1'b0;
    refresh     = 1'b0;
    swallowed   = 1'b0;
    case (s1_func_r)
      FN_TICK: begin
        if (!hold_r) begin
          // a deferred wake returns to active before the idle check
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (mode_r != MODE_ACTIVE) begin
              mode_nxt    = MODE_ACTIVE;
              level_nxt   = FULL_LEVEL;
              clk_vis_nxt = 1'b0;
              wrote       = 1'b1;
              set_clk     = 1'b1;
            end
          end
          if (target != mode_nxt) begin
            mode_nxt    = target;
            level_nxt   = mode_level(target, cfg);
            clk_vis_nxt = target inside {MODE_CLOCK, MODE_DIM2, MODE_OFF};
            wrote       = 1'b1;
            set_clk     = 1'b1;
          end
          refresh = mode_nxt inside {MODE_CLOCK, MODE_DIM2, MODE_OFF};
        end
      end
      FN_TOUCH: begin
        if (!hold_r) begin
          last_nxt = s1_now_r;
          if (mode_r == MODE_DIM) begin
            mode_nxt  = MODE_ACTIVE;
            level_nxt = FULL_LEVEL;
            wrote     = 1'b1;
          end else if (mode_r != MODE_ACTIVE) begin
            // deep mode: light up now, swallow the touch, wake on next tick
            supp_nxt  = 1'b1;
            pend_nxt  = 1'b1;
            level_nxt = FULL_LEVEL;
            wrote     = 1'b1;
            swallowed = 1'b1;
          end
        end
      end
      FN_RELEASE: begin
        supp_nxt = 1'b0;
      end
      FN_SET_HOLD: begin
        hold_nxt = s1_hold_req_r;
        last_nxt = s1_now_r;
      end
      FN_ALERT: begin
        if (!hold_r) begin
          last_nxt = s1_now_r;
          if (mode_r != MODE_ACTIVE) begin
            pend_nxt = 1'b1;
          end
          level_nxt = FULL_LEVEL;
          wrote     = 1'b1;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase

    res_nxt.mode            = mode_nxt;
    res_nxt.backlight_write = wrote;
    res_nxt.backlight_level = level_nxt;
    res_nxt.clock_changed   = set_clk;
    res_nxt.clock_visible   = clk_vis_nxt;
    res_nxt.clock_refresh   = refresh;
    res_nxt.wake_swallowed  = swallowed;
    res_nxt.tile_allowed    = !supp_nxt && (mode_nxt == MODE_ACTIVE || mode_nxt == MODE_DIM);
    res_nxt.hold_active     = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_ACTIVE;
      last_r      <= '0;
      pend_r      <= 1'b0;
      hold_r      <= 1'b0;
      supp_r      <= 1'b0;
      clk_vis_r   <= 1'b0;
      level_r     <= FULL_LEVEL;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        mode_r    <= mode_nxt;
        last_r    <= last_nxt;
        pend_r    <= pend_nxt;
        hold_r    <= hold_nxt;
        supp_r    <= supp_nxt;
        clk_vis_r <= clk_vis_nxt;
        level_r   <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r     <= in_func;
      s1_now_r      <= in_now_ms;
      s1_hold_req_r <= in_hold_request;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/dibc_checker.sv =====
module dibc_checker import dibc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [MODE_W-1:0]    out_mode,
  input logic                 out_backlight_write,
  input logic [LEVEL_W-1:0]   out_backlight_level,
  input logic                 out_wake_swallowed,
  input logic                 out_tile_allowed
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode)
      && $stable(out_backlight_level))
    else $error("stalled result changed");

  a_tile_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tile_allowed |-> out_mode == MODE_ACTIVE || out_mode == MODE_DIM)
    else $error("tile presses allowed in a deep mode");

  a_swallow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_swallowed |-> out_backlight_write
      && out_backlight_level == FULL_LEVEL && !out_tile_allowed)
    else $error("swallowed wake without full backlight and suppress");

  a_active_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_backlight_write && out_mode == MODE_ACTIVE
      |-> out_backlight_level == FULL_LEVEL)
    else $error("backlight write in active mode not full level");

endmodule

bind display_idle_backlight_controller_unit dibc_checker u_dibc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_mode            (out_mode),
  .out_backlight_write (out_backlight_write),
  .out_backlight_level (out_backlight_level),
  .out_wake_swallowed  (out_wake_swallowed),
  .out_tile_allowed    (out_tile_allowed)
);

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dibc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [FUNC_W-1:0] FN_RSVD_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_LAST = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [TIME_BITS-1:0] in_now_ms = '0;
  logic in_hold_request = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MODE_W-1:0] out_mode;
  logic out_backlight_write;
  logic [LEVEL_W-1:0] out_backlight_level;
  logic out_clock_changed;
  logic out_clock_visible;
  logic out_clock_refresh;
  logic out_wake_swallowed;
  logic out_tile_allowed;
  logic out_hold_active;

  // predictor state
  dibc_cfg_t m_cfg;
  logic [MODE_W-1:0] m_mode;
  logic [TIME_BITS-1:0] m_last_ms;
  logic m_wake_due, m_hold, m_suppress, m_clock_on;
  logic [LEVEL_W-1:0] m_level;
  logic m_wrote, m_clock_set;
  dibc_res_t status_fifo[$];

  int errors = 0;
  int cycles = 0;
  int words_checked = 0;
  int holdoff_req = 0;
  int holdoff_left = 0;
  bit stall_on = 1'b0;
  bit gaps_on = 1'b0;
  int burst_left = 0;
  logic [15:0] stall_pattern = 16'h0;
  int pat_pos = 0;
  logic [TIME_BITS-1:0] wall_ms = '0;

  display_idle_backlight_controller_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void reset_model();
    m_cfg.dim_seconds = 16'd30;
    m_cfg.clock_seconds = 16'd60;
    m_cfg.deep_dim_seconds = 16'd300;
    m_cfg.off_seconds = 16'd600;
    m_cfg.dim_percent = 7'd30;
    m_cfg.deep_dim_percent = 7'd10;
    m_mode = MODE_ACTIVE;
    m_last_ms = '0;
    m_wake_due = 1'b0;
    m_hold = 1'b0;
    m_suppress = 1'b0;
    m_clock_on = 1'b0;
    m_level = FULL_LEVEL;
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_percent(logic [LEVEL_W-1:0] v);
    if (v < MIN_PERCENT) return MIN_PERCENT;
    if (v > MAX_PERCENT) return MAX_PERCENT;
    return v;
  endfunction

  function automatic void put_light(logic [LEVEL_W-1:0] pct);
    m_level = pct;
    m_wrote = 1'b1;
  endfunction

  function automatic void show_clock(logic on);
    m_clock_on = on;
    m_clock_set = 1'b1;
  endfunction

  function automatic void enter_mode(logic [MODE_W-1:0] next);
    if (next == m_mode) return;
    m_mode = next;
    case (next)
      MODE_ACTIVE: begin put_light(FULL_LEVEL); show_clock(1'b0); end
      MODE_DIM: begin put_light(m_cfg.dim_percent); show_clock(1'b0); end
      MODE_CLOCK: begin put_light(m_cfg.dim_percent); show_clock(1'b1); end
      MODE_DIM2: begin put_light(m_cfg.deep_dim_percent); show_clock(1'b1); end
      default: begin put_light(OFF_LEVEL); show_clock(1'b1); end
    endcase
  endfunction

  function automatic logic threshold_hit(logic [TIME_BITS-1:0] idle, logic [SECS_W-1:0] secs);
    return secs != '0 && idle >= 32'(secs) * 32'(MS_PER_SEC);
  endfunction

  // deepest enabled level that the idle time has reached
  function automatic logic [MODE_W-1:0] mode_after_idle(logic [TIME_BITS-1:0] idle);
    if (threshold_hit(idle, m_cfg.off_seconds)) return MODE_OFF;
    if (threshold_hit(idle, m_cfg.deep_dim_seconds)) return MODE_DIM2;
    if (threshold_hit(idle, m_cfg.clock_seconds)) return MODE_CLOCK;
    if (threshold_hit(idle, m_cfg.dim_seconds)) return MODE_DIM;
    return MODE_ACTIVE;
  endfunction

  function automatic dibc_res_t apply_event(logic [FUNC_W-1:0] fn, logic [TIME_BITS-1:0] now,
                                            logic req);
    dibc_res_t r;
    logic refresh;
    logic swallowed;
    refresh = 1'b0;
    swallowed = 1'b0;
    m_wrote = 1'b0;
    m_clock_set = 1'b0;
    case (fn)
      FN_TICK: begin
        if (!m_hold) begin
          if (m_wake_due) begin
            m_wake_due = 1'b0;
            enter_mode(MODE_ACTIVE);
          end
          enter_mode(mode_after_idle(now - m_last_ms));
          refresh = m_mode >= MODE_CLOCK;
        end
      end
      FN_TOUCH: begin
        if (!m_hold) begin
          m_last_ms = now;
          if (m_mode == MODE_DIM) begin
            put_light(FULL_LEVEL);
            m_mode = MODE_ACTIVE;
          end else if (m_mode != MODE_ACTIVE) begin
            // deep mode: light up now, go active on the next tick
            m_suppress = 1'b1;
            m_wake_due = 1'b1;
            put_light(FULL_LEVEL);
            swallowed = 1'b1;
          end
        end
      end
      FN_RELEASE: m_suppress = 1'b0;
      FN_SET_HOLD: begin
        m_hold = req;
        m_last_ms = now;
      end
      FN_ALERT: begin
        if (!m_hold) begin
          m_last_ms = now;
          if (m_mode != MODE_ACTIVE) m_wake_due = 1'b1;
          put_light(FULL_LEVEL);
        end
      end
      default: ;
    endcase
    r.mode = m_mode;
    r.backlight_write = m_wrote;
    r.backlight_level = m_level;
    r.clock_changed = m_clock_set;
    r.clock_visible = m_clock_on;
    r.clock_refresh = refresh;
    r.wake_swallowed = swallowed;
    r.tile_allowed = !m_suppress && m_mode <= MODE_DIM;
    r.hold_active = m_hold;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 40) $display("[%0t] word %0d: %s", $time, words_checked, what);
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic send_word(logic [FUNC_W-1:0] fn, logic [TIME_BITS-1:0] now, logic req);
    int gap;
    in_valid <= 1'b1;
    in_func <= fn;
    in_now_ms <= now;
    in_hold_request <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_fifo.push_back(apply_event(fn, now, req));
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DIM_SECS: m_cfg.dim_seconds = data;
      REG_CLOCK_SECS: m_cfg.clock_seconds = data;
      REG_DEEP_DIM_SECS: m_cfg.deep_dim_seconds = data;
      REG_OFF_SECS: m_cfg.off_seconds = data;
      REG_DIM_PERCENT: m_cfg.dim_percent = clamp_percent(data[LEVEL_W-1:0]);
      REG_DEEP_DIM_PCT: m_cfg.deep_dim_percent = clamp_percent(data[LEVEL_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_word(int unsigned max_step);
    int pick;
    logic [TIME_BITS-1:0] now;
    logic [FUNC_W-1:0] fn;
    logic req;
    pick = $urandom_range(0, 99);
    req = 1'($urandom_range(0, 1));
    // mostly a forward-running clock, now and then a stray timestamp
    if ($urandom_range(0, 39) == 0) begin
      now = $urandom;
    end else begin
      wall_ms += $urandom_range(0, max_step);
      now = wall_ms;
    end
    if (pick < 50) fn = FN_TICK;
    else if (pick < 64) fn = FN_TOUCH;
    else if (pick < 74) fn = FN_RELEASE;
    else if (pick < 82) begin
      fn = FN_SET_HOLD;
      req = $urandom_range(0, 2) == 0;
    end else if (pick < 92) fn = FN_ALERT;
    else fn = FUNC_W'($urandom_range(FN_RSVD_FIRST, FN_RSVD_LAST));
    send_word(fn, now, req);
  endtask

  task automatic program_thresholds(bit wide);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < 4; i++) begin
      idx = REG_DIM_SECS + CFG_IDX_W'(i);
      if ($urandom_range(0, 5) == 0) v = '0;
      else v = wide ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 20));
      write_register(idx, v);
    end
    write_register(REG_DIM_PERCENT,
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 127)));
    write_register(REG_DEEP_DIM_PCT,
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 127)));
    if ($urandom_range(0, 2) == 0)
      write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
  endtask

  // receiver: long hold-off on request, else a rotating stall pattern
  always @(posedge clk) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (stall_on) begin
      out_stall <= stall_pattern[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
      if (pat_pos == 0 && $urandom_range(0, 3) == 0)
        stall_pattern = 16'($urandom & $urandom) & 16'hFFFE;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    dibc_res_t got;
    dibc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.mode = out_mode;
      got.backlight_write = out_backlight_write;
      got.backlight_level = out_backlight_level;
      got.clock_changed = out_clock_changed;
      got.clock_visible = out_clock_visible;
      got.clock_refresh = out_clock_refresh;
      got.wake_swallowed = out_wake_swallowed;
      got.tile_allowed = out_tile_allowed;
      got.hold_active = out_hold_active;
      if (status_fifo.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = status_fifo.pop_front();
        compare_field("mode", 32'(got.mode), 32'(want.mode));
        compare_field("backlight_write", 32'(got.backlight_write),
                      32'(want.backlight_write));
        compare_field("backlight_level", 32'(got.backlight_level),
                      32'(want.backlight_level));
        compare_field("clock_changed", 32'(got.clock_changed), 32'(want.clock_changed));
        compare_field("clock_visible", 32'(got.clock_visible), 32'(want.clock_visible));
        compare_field("clock_refresh", 32'(got.clock_refresh), 32'(want.clock_refresh));
        compare_field("wake_swallowed", 32'(got.wake_swallowed), 32'(want.wake_swallowed));
        compare_field("tile_allowed", 32'(got.tile_allowed), 32'(want.tile_allowed));
        compare_field("hold_active", 32'(got.hold_active), 32'(want.hold_active));
      end
      words_checked++;
    end
  end

  // walk every mode with the reset thresholds, then hold, unused codes and wrap
  task automatic test_directed();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    stall_pattern = 16'h1248;
    send_word(FN_TICK, 32'd0, 1'b0);
    send_word(FN_TICK, 32'd29999, 1'b1);
    send_word(FN_TICK, 32'd30000, 1'b0);
    send_word(FN_TOUCH, 32'd30500, 1'b0);
    send_word(FN_TICK, 32'd90500, 1'b0);
    send_word(FN_TOUCH, 32'd90600, 1'b0);
    send_word(FN_TOUCH, 32'd90650, 1'b1);
    send_word(FN_TICK, 32'd90700, 1'b0);
    send_word(FN_RELEASE, 32'd90700, 1'b0);
    send_word(FN_TICK, 32'd390650, 1'b0);
    send_word(FN_TICK, 32'd690650, 1'b0);
    send_word(FN_ALERT, 32'd690700, 1'b0);
    send_word(FN_TICK, 32'd690800, 1'b0);
    send_word(FN_SET_HOLD, 32'd700000, 1'b1);
    send_word(FN_TICK, 32'd2000000, 1'b0);
    send_word(FN_TOUCH, 32'd2000000, 1'b0);
    send_word(FN_ALERT, 32'd2000000, 1'b0);
    send_word(FN_RELEASE, 32'd2000000, 1'b0);
    send_word(FN_SET_HOLD, 32'd2000000, 1'b0);
    send_word(FN_RSVD_FIRST, 32'hFFFF_FFFF, 1'b1);
    send_word(FN_RSVD_MID, 32'h5555_AAAA, 1'b0);
    send_word(FN_RSVD_LAST, 32'd0, 1'b0);
    send_word(FN_SET_HOLD, 32'hFFFF_F000, 1'b0);
    send_word(FN_TICK, 32'h0000_7000, 1'b0);
    send_word(FN_TICK, 32'hFFFF_EFFF, 1'b0);
  endtask

  // threshold and percent extremes, clamping and ignored indexes
  task automatic test_registers();
    wait_drained();
    write_register(REG_DIM_SECS, 16'hFFFF);
    write_register(REG_CLOCK_SECS, 16'h0000);
    write_register(REG_DEEP_DIM_SECS, 16'h0000);
    write_register(REG_OFF_SECS, 16'h0000);
    write_register(REG_DIM_PERCENT, 16'h0000);
    write_register(REG_DEEP_DIM_PCT, 16'hFFFF);
    write_register(REG_SPARE_LO, 16'hFFFF);
    write_register(REG_SPARE_HI, 16'h0000);
    send_word(FN_SET_HOLD, 32'd100, 1'b0);
    send_word(FN_TICK, 32'd100 + 32'd65534999, 1'b0);
    send_word(FN_TICK, 32'd100 + 32'd65535000, 1'b0);
    send_word(FN_TOUCH, 32'd100 + 32'd65535000, 1'b0);
    wait_drained();
    write_register(REG_OFF_SECS, 16'hFFFF);
    write_register(REG_DEEP_DIM_SECS, 16'd2);
    write_register(REG_DIM_SECS, 16'd1);
    write_register(REG_DIM_PERCENT, 16'd200);
    write_register(REG_DEEP_DIM_PCT, 16'd100);
    send_word(FN_SET_HOLD, 32'd1000, 1'b0);
    send_word(FN_TICK, 32'd1999, 1'b0);
    send_word(FN_TICK, 32'd2000, 1'b0);
    send_word(FN_TICK, 32'd3000, 1'b0);
    send_word(FN_TICK, 32'd1000 + 32'd65535000, 1'b0);
    send_word(FN_TOUCH, 32'd1000 + 32'd65535001, 1'b0);
    send_word(FN_TICK, 32'd1000 + 32'd65535002, 1'b0);
    send_word(FN_RELEASE, 32'd1000 + 32'd65535002, 1'b0);
  endtask

  // hold the output off while words keep coming so the input side backs up
  task automatic test_backpressure();
    wait_drained();
    program_thresholds(1'b0);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    wall_ms = 32'd5000;
    holdoff_req = 60;
    repeat (24) send_random_word(3000);
    wait_drained();
  endtask

  task automatic test_random_phases();
    bit wide;
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      wide = (p % 3) == 2;
      program_thresholds(wide);
      gaps_on = (p % 4) != 0;
      stall_on = (p % 3) != 0;
      if (p == 5) wall_ms = 32'hFFF0_0000;
      for (int i = 0; i < 100; i++) begin
        send_random_word(wide ? 8000000 : 6000);
        if (p == 2 && i == 50) holdoff_req = 40;
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_registers();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
